// ===== rtl/pfks_pkg.sv =====
// Shared types, constants and the sequencer microprogram for the prime field key schedule.
// Used by pfks_mod_unit and prime_field_key_schedule; depends on nothing else.
`timescale 1ns / 1ps

package pfks_pkg;

	localparam int KEY_WORDS  = 16;
	localparam int WORD_BITS  = 17;
	localparam int MAX_GROUPS = 56;
	localparam int ACC_BITS   = WORD_BITS + 2;   // sum of three words
	localparam int GROUP_BITS = 6;
	localparam int COUNT_BITS = 4;
	localparam int KIDX_BITS  = 4;
	localparam int CFG_BITS   = 2;
	localparam int PC_BITS    = 6;
	localparam int CIDX_BITS  = 8;               // 4*group + lane + 1
	localparam int MU_STEPS   = ACC_BITS;        // one multiplier bit per cycle
	localparam int MU_CNT_BITS = $clog2(MU_STEPS);

	typedef logic [WORD_BITS-1:0]  word_t;
	typedef logic [ACC_BITS-1:0]   acc_t;
	typedef logic [GROUP_BITS-1:0] group_t;

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_GEN  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_BITS-1:0] CFG_MODULUS = 2'd0;
	localparam logic [CFG_BITS-1:0] CFG_RCONST  = 2'd1;
	localparam logic [CFG_BITS-1:0] CFG_ROUNDS  = 2'd2;

	localparam word_t                 MODULUS_RST = 17'd65537;
	localparam word_t                 RCONST_RST  = 17'd0;
	localparam logic [COUNT_BITS-1:0] ROUNDS_RST  = 4'd12;

	typedef struct packed {
		logic                 req_type;
		logic [KIDX_BITS-1:0] key_index;
		word_t                key_word;
	} key_req_t;

	typedef struct packed {
		word_t  round_key_a;
		word_t  round_key_b;
		word_t  round_key_c;
		word_t  round_key_d;
		group_t group_index;
		logic   error_flag;
	} rkey_t;

	typedef enum logic {
		MOP_MUL,
		MOP_SUB
	} mod_op_t;

	typedef struct packed {
		logic    start;
		mod_op_t op;
	} mu_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_FIN
	} seq_state_t;

	typedef enum logic [2:0] {
		UOP_LDACC,
		UOP_ADDACC,
		UOP_MUL,
		UOP_SUB,
		UOP_SHR,
		UOP_SHC,
		UOP_END
	} uop_t;

	typedef enum logic [3:0] {
		SRC_ZERO, SRC_ONE, SRC_RCRAW, SRC_ACC, SRC_WIN, SRC_CIDX,
		SRC_R0, SRC_R1, SRC_R2, SRC_R3,
		SRC_C0, SRC_C1, SRC_C2, SRC_C3,
		SRC_RC, SRC_P
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE,
		DST_R0, DST_R1, DST_R2, DST_R3,
		DST_C0, DST_C1, DST_C2, DST_C3,
		DST_RC, DST_P
	} dst_t;

	typedef struct packed {
		uop_t                 op;
		src_t                 sa;
		src_t                 sb;
		dst_t                 dst;
		logic [KIDX_BITS-1:0] widx;
		logic [1:0]           cidx;
	} ucode_t;

	function automatic ucode_t mk(uop_t op, src_t sa, src_t sb, dst_t dst,
			logic [KIDX_BITS-1:0] widx, logic [1:0] cidx);
		ucode_t u;
		u.op   = op;
		u.sa   = sa;
		u.sb   = sb;
		u.dst  = dst;
		u.widx = widx;
		u.cidx = cidx;
		return u;
	endfunction

	// MUL with SRC_ONE as multiplicand is a plain reduction of the multiplier.
	function automatic ucode_t ucode(logic [PC_BITS-1:0] pc);
		ucode_t u;
		case (pc)
			6'd0:  u = mk(UOP_MUL,    SRC_ONE,  SRC_RCRAW, DST_RC,   4'd0,  2'd0);
			// lane sums, stored already rotated left by three
			6'd1:  u = mk(UOP_LDACC,  SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd4,  2'd0);
			6'd2:  u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd8,  2'd0);
			6'd3:  u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd12, 2'd0);
			6'd4:  u = mk(UOP_MUL,    SRC_ONE,  SRC_ACC,   DST_R1,   4'd0,  2'd0);
			6'd5:  u = mk(UOP_LDACC,  SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd5,  2'd0);
			6'd6:  u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd9,  2'd0);
			6'd7:  u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd13, 2'd0);
			6'd8:  u = mk(UOP_MUL,    SRC_ONE,  SRC_ACC,   DST_R2,   4'd0,  2'd0);
			6'd9:  u = mk(UOP_LDACC,  SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd6,  2'd0);
			6'd10: u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd10, 2'd0);
			6'd11: u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd14, 2'd0);
			6'd12: u = mk(UOP_MUL,    SRC_ONE,  SRC_ACC,   DST_R3,   4'd0,  2'd0);
			6'd13: u = mk(UOP_LDACC,  SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd7,  2'd0);
			6'd14: u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd11, 2'd0);
			6'd15: u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd15, 2'd0);
			6'd16: u = mk(UOP_MUL,    SRC_ONE,  SRC_ACC,   DST_R0,   4'd0,  2'd0);
			// S-box on the rotated sums
			6'd17: u = mk(UOP_MUL,    SRC_R0,   SRC_R1,    DST_P,    4'd0,  2'd0);
			6'd18: u = mk(UOP_SUB,    SRC_R3,   SRC_P,     DST_P,    4'd0,  2'd0);
			6'd19: u = mk(UOP_SUB,    SRC_P,    SRC_R2,    DST_P,    4'd0,  2'd0);
			6'd20: u = mk(UOP_SUB,    SRC_P,    SRC_RC,    DST_P,    4'd0,  2'd0);
			6'd21: u = mk(UOP_SHR,    SRC_ZERO, SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			// group constant
			6'd22: u = mk(UOP_MUL,    SRC_ONE,  SRC_CIDX,  DST_C0,   4'd0,  2'd0);
			6'd23: u = mk(UOP_MUL,    SRC_ONE,  SRC_CIDX,  DST_C1,   4'd0,  2'd1);
			6'd24: u = mk(UOP_MUL,    SRC_ONE,  SRC_CIDX,  DST_C2,   4'd0,  2'd2);
			6'd25: u = mk(UOP_MUL,    SRC_ONE,  SRC_CIDX,  DST_C3,   4'd0,  2'd3);
			6'd26: u = mk(UOP_MUL,    SRC_C0,   SRC_C1,    DST_P,    4'd0,  2'd0);
			6'd27: u = mk(UOP_SUB,    SRC_C3,   SRC_P,     DST_P,    4'd0,  2'd0);
			6'd28: u = mk(UOP_SUB,    SRC_P,    SRC_C2,    DST_P,    4'd0,  2'd0);
			6'd29: u = mk(UOP_SUB,    SRC_P,    SRC_RC,    DST_P,    4'd0,  2'd0);
			6'd30: u = mk(UOP_SHC,    SRC_ZERO, SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			// sbox + constant + low window word, reduced once
			6'd31: u = mk(UOP_LDACC,  SRC_R0,   SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			6'd32: u = mk(UOP_ADDACC, SRC_C0,   SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			6'd33: u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			6'd34: u = mk(UOP_MUL,    SRC_ONE,  SRC_ACC,   DST_R0,   4'd0,  2'd0);
			6'd35: u = mk(UOP_LDACC,  SRC_R1,   SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			6'd36: u = mk(UOP_ADDACC, SRC_C1,   SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			6'd37: u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd1,  2'd0);
			6'd38: u = mk(UOP_MUL,    SRC_ONE,  SRC_ACC,   DST_R1,   4'd0,  2'd0);
			6'd39: u = mk(UOP_LDACC,  SRC_R2,   SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			6'd40: u = mk(UOP_ADDACC, SRC_C2,   SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			6'd41: u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd2,  2'd0);
			6'd42: u = mk(UOP_MUL,    SRC_ONE,  SRC_ACC,   DST_R2,   4'd0,  2'd0);
			6'd43: u = mk(UOP_LDACC,  SRC_R3,   SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			6'd44: u = mk(UOP_ADDACC, SRC_C3,   SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
			6'd45: u = mk(UOP_ADDACC, SRC_WIN,  SRC_ZERO,  DST_NONE, 4'd3,  2'd0);
			6'd46: u = mk(UOP_MUL,    SRC_ONE,  SRC_ACC,   DST_R3,   4'd0,  2'd0);
			default: u = mk(UOP_END,  SRC_ZERO, SRC_ZERO,  DST_NONE, 4'd0,  2'd0);
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/pfks_mod_unit.sv =====
// Shared modular unit: bit-serial multiply-reduce (a * b mod m) and modular subtract.
// Depends on pfks_pkg.
`timescale 1ns / 1ps

module pfks_mod_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  pfks_pkg::mu_cmd_t cmd,
	input  pfks_pkg::word_t  a,
	input  pfks_pkg::acc_t   b,
	input  pfks_pkg::word_t  m,
	output logic             done,
	output pfks_pkg::word_t  res
);

	logic                               busy_q;
	logic                               done_q;
	logic [pfks_pkg::MU_CNT_BITS-1:0]   cnt_q;
	pfks_pkg::word_t                    a_q;
	pfks_pkg::acc_t                     b_q;
	pfks_pkg::word_t                    r_q;

	pfks_pkg::acc_t  x;
	pfks_pkg::acc_t  m1;
	pfks_pkg::acc_t  m2;
	pfks_pkg::word_t step_r;
	logic [pfks_pkg::WORD_BITS:0] sub_raw;
	pfks_pkg::word_t sub_r;

	// Horner step: r = 2r + bit*a, then at most two subtractions of m
	always_comb begin
		m1 = pfks_pkg::ACC_BITS'(m);
		m2 = pfks_pkg::ACC_BITS'({m, 1'b0});
		x  = pfks_pkg::ACC_BITS'({r_q, 1'b0})
			+ (b_q[pfks_pkg::ACC_BITS-1] ? pfks_pkg::ACC_BITS'(a_q) : '0);
		if (x >= m2) begin
			step_r = pfks_pkg::WORD_BITS'(x - m2);
		end else if (x >= m1) begin
			step_r = pfks_pkg::WORD_BITS'(x - m1);
		end else begin
			step_r = x[pfks_pkg::WORD_BITS-1:0];
		end
	end

	// operands already below m, so a + m - b < 2m
	always_comb begin
		sub_raw = {1'b0, a} + {1'b0, m} - {1'b0, b[pfks_pkg::WORD_BITS-1:0]};
		if (sub_raw >= {1'b0, m}) begin
			sub_r = pfks_pkg::WORD_BITS'(sub_raw - {1'b0, m});
		end else begin
			sub_r = sub_raw[pfks_pkg::WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				if (cmd.op == pfks_pkg::MOP_SUB) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= pfks_pkg::MU_CNT_BITS'(pfks_pkg::MU_STEPS - 1);
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= a;
			b_q <= b;
			r_q <= (cmd.op == pfks_pkg::MOP_SUB) ? sub_r : '0;
		end else if (busy_q) begin
			r_q <= step_r;
			b_q <= {b_q[pfks_pkg::ACC_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

// ===== rtl/prime_field_key_schedule.sv =====
// Prime field key schedule: 16-word key window, microcoded sequencer over one modular unit.
// Load: writes one window word, no result. Refused generate: error-flagged result.
// Generate: runs the microprogram, with 15 products on the bit-serial multiply-reduce
// unit, 6 modular subtractions and the accumulate and shift steps between them.
// One request at a time: the next request is taken in the cycle the result appears.
// Reset: window, group counter cleared; modulus 65537, round constant 0, rounds 12.
// Depends on pfks_pkg and pfks_mod_unit.
`timescale 1ns / 1ps

module prime_field_key_schedule (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          key_req_valid,
	output logic                          key_req_stall,
	input  pfks_pkg::key_req_t            key_req,
	output logic                          rkey_valid,
	input  logic                          rkey_stall,
	output pfks_pkg::rkey_t               rkey,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfks_pkg::CFG_BITS-1:0] cfg_index,
	input  pfks_pkg::word_t               cfg_data
);

	pfks_pkg::seq_state_t state_q, state_d;
	logic [pfks_pkg::PC_BITS-1:0]    pc_q;
	pfks_pkg::group_t                gcnt_q;
	logic                            out_valid_q;
	pfks_pkg::rkey_t                 rkey_q;
	logic                            err_q;

	pfks_pkg::word_t                 m_q;
	pfks_pkg::word_t                 rcraw_q;
	logic [pfks_pkg::COUNT_BITS-1:0] rcount_q;

	pfks_pkg::word_t win_q [pfks_pkg::KEY_WORDS];
	pfks_pkg::acc_t  acc_q;
	pfks_pkg::word_t r0_q, r1_q, r2_q, r3_q;
	pfks_pkg::word_t c0_q, c1_q, c2_q, c3_q;
	pfks_pkg::word_t rc_q, p_q;

	pfks_pkg::ucode_t  uc;
	pfks_pkg::mu_cmd_t mu_cmd;
	logic              mu_done;
	pfks_pkg::word_t   mu_res;
	pfks_pkg::word_t   win_rd;
	pfks_pkg::acc_t    sa_val, sb_val;
	logic [pfks_pkg::CIDX_BITS-1:0] cidx_val;

	logic              in_acc, out_free, fin_fire, refuse, m_ok, is_unit_op;
	pfks_pkg::group_t  rc4, limit;
	pfks_pkg::word_t   res_a, res_b, res_c, res_d;

	assign uc       = pfks_pkg::ucode(pc_q);
	assign in_acc   = key_req_valid && !key_req_stall;
	assign out_free = !out_valid_q || !rkey_stall;
	assign win_rd   = win_q[uc.widx];
	assign cidx_val = pfks_pkg::CIDX_BITS'({gcnt_q, 2'b00})
		+ pfks_pkg::CIDX_BITS'(uc.cidx) + pfks_pkg::CIDX_BITS'(1);
	assign is_unit_op = (uc.op == pfks_pkg::UOP_MUL) || (uc.op == pfks_pkg::UOP_SUB);

	assign rc4    = {rcount_q, 2'b00};
	assign limit  = (rc4 > pfks_pkg::GROUP_BITS'(pfks_pkg::MAX_GROUPS))
		? pfks_pkg::GROUP_BITS'(pfks_pkg::MAX_GROUPS) : rc4;
	assign refuse = gcnt_q >= limit;

	// modulus 0 or 1 gives all-zero words
	assign m_ok  = m_q > pfks_pkg::WORD_BITS'(1);
	assign res_a = m_ok ? r0_q : '0;
	assign res_b = m_ok ? r1_q : '0;
	assign res_c = m_ok ? r2_q : '0;
	assign res_d = m_ok ? r3_q : '0;

	function automatic pfks_pkg::acc_t pick(pfks_pkg::src_t s);
		pfks_pkg::acc_t v;
		case (s)
			pfks_pkg::SRC_ZERO:  v = '0;
			pfks_pkg::SRC_ONE:   v = pfks_pkg::ACC_BITS'(1);
			pfks_pkg::SRC_RCRAW: v = pfks_pkg::ACC_BITS'(rcraw_q);
			pfks_pkg::SRC_ACC:   v = acc_q;
			pfks_pkg::SRC_WIN:   v = pfks_pkg::ACC_BITS'(win_rd);
			pfks_pkg::SRC_CIDX:  v = pfks_pkg::ACC_BITS'(cidx_val);
			pfks_pkg::SRC_R0:    v = pfks_pkg::ACC_BITS'(r0_q);
			pfks_pkg::SRC_R1:    v = pfks_pkg::ACC_BITS'(r1_q);
			pfks_pkg::SRC_R2:    v = pfks_pkg::ACC_BITS'(r2_q);
			pfks_pkg::SRC_R3:    v = pfks_pkg::ACC_BITS'(r3_q);
			pfks_pkg::SRC_C0:    v = pfks_pkg::ACC_BITS'(c0_q);
			pfks_pkg::SRC_C1:    v = pfks_pkg::ACC_BITS'(c1_q);
			pfks_pkg::SRC_C2:    v = pfks_pkg::ACC_BITS'(c2_q);
			pfks_pkg::SRC_C3:    v = pfks_pkg::ACC_BITS'(c3_q);
			pfks_pkg::SRC_RC:    v = pfks_pkg::ACC_BITS'(rc_q);
			pfks_pkg::SRC_P:     v = pfks_pkg::ACC_BITS'(p_q);
			default:             v = '0;
		endcase
		return v;
	endfunction

	// operand values follow the registers read inside pick, not only the select
	always_comb begin
		sa_val = pick(uc.sa);
		sb_val = pick(uc.sb);
	end

	pfks_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mu_cmd),
		.a      (sa_val[pfks_pkg::WORD_BITS-1:0]),
		.b      (sb_val),
		.m      (m_q),
		.done   (mu_done),
		.res    (mu_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfks_pkg::ST_IDLE: begin
				if (in_acc && key_req.req_type == pfks_pkg::REQ_GEN) begin
					state_d = refuse ? pfks_pkg::ST_FIN : pfks_pkg::ST_ISSUE;
				end
			end
			pfks_pkg::ST_ISSUE: begin
				if (is_unit_op) begin
					state_d = pfks_pkg::ST_WAIT;
				end else if (uc.op == pfks_pkg::UOP_END) begin
					state_d = pfks_pkg::ST_FIN;
				end
			end
			pfks_pkg::ST_WAIT: begin
				if (mu_done) begin
					state_d = pfks_pkg::ST_ISSUE;
				end
			end
			pfks_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = pfks_pkg::ST_IDLE;
				end
			end
			default: state_d = pfks_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		key_req_stall = 1'b1;
		mu_cmd.start  = 1'b0;
		mu_cmd.op     = (uc.op == pfks_pkg::UOP_SUB) ? pfks_pkg::MOP_SUB : pfks_pkg::MOP_MUL;
		fin_fire      = 1'b0;
		case (state_q)
			pfks_pkg::ST_IDLE:  key_req_stall = 1'b0;
			pfks_pkg::ST_ISSUE: mu_cmd.start  = is_unit_op;
			pfks_pkg::ST_WAIT:  mu_cmd.start  = 1'b0;
			pfks_pkg::ST_FIN:   fin_fire      = out_free;
			default:            key_req_stall = 1'b1;
		endcase
	end

	assign cfg_ready  = 1'b1;
	assign rkey_valid = out_valid_q;
	assign rkey       = rkey_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfks_pkg::ST_IDLE;
			pc_q        <= '0;
			gcnt_q      <= '0;
			out_valid_q <= 1'b0;
			m_q         <= pfks_pkg::MODULUS_RST;
			rcraw_q     <= pfks_pkg::RCONST_RST;
			rcount_q    <= pfks_pkg::ROUNDS_RST;
			for (int i = 0; i < pfks_pkg::KEY_WORDS; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pfks_pkg::CFG_MODULUS: m_q      <= cfg_data;
					pfks_pkg::CFG_RCONST:  rcraw_q  <= cfg_data;
					pfks_pkg::CFG_ROUNDS:  rcount_q <= cfg_data[pfks_pkg::COUNT_BITS-1:0];
					default: ;
				endcase
			end

			if (in_acc) begin
				pc_q <= '0;
			end else if ((state_q == pfks_pkg::ST_ISSUE && !is_unit_op
					&& uc.op != pfks_pkg::UOP_END)
					|| (state_q == pfks_pkg::ST_WAIT && mu_done)) begin
				pc_q <= pc_q + 1'b1;
			end

			if (in_acc && key_req.req_type == pfks_pkg::REQ_LOAD) begin
				win_q[key_req.key_index] <= key_req.key_word;
				gcnt_q <= '0;
			end else if (fin_fire && !err_q) begin
				for (int i = 0; i < pfks_pkg::KEY_WORDS - 4; i++) begin
					win_q[i] <= win_q[i + 4];
				end
				win_q[pfks_pkg::KEY_WORDS - 4] <= res_a;
				win_q[pfks_pkg::KEY_WORDS - 3] <= res_b;
				win_q[pfks_pkg::KEY_WORDS - 2] <= res_c;
				win_q[pfks_pkg::KEY_WORDS - 1] <= res_d;
				gcnt_q <= gcnt_q + 1'b1;
			end

			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rkey_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q <= refuse;
		end

		if (state_q == pfks_pkg::ST_ISSUE) begin
			case (uc.op)
				pfks_pkg::UOP_LDACC:  acc_q <= sa_val;
				pfks_pkg::UOP_ADDACC: acc_q <= acc_q + sa_val;
				pfks_pkg::UOP_SHR: begin
					r3_q <= r2_q;
					r2_q <= r1_q;
					r1_q <= r0_q;
					r0_q <= p_q;
				end
				pfks_pkg::UOP_SHC: begin
					c3_q <= c2_q;
					c2_q <= c1_q;
					c1_q <= c0_q;
					c0_q <= p_q;
				end
				default: ;
			endcase
		end

		if (state_q == pfks_pkg::ST_WAIT && mu_done) begin
			case (uc.dst)
				pfks_pkg::DST_R0: r0_q <= mu_res;
				pfks_pkg::DST_R1: r1_q <= mu_res;
				pfks_pkg::DST_R2: r2_q <= mu_res;
				pfks_pkg::DST_R3: r3_q <= mu_res;
				pfks_pkg::DST_C0: c0_q <= mu_res;
				pfks_pkg::DST_C1: c1_q <= mu_res;
				pfks_pkg::DST_C2: c2_q <= mu_res;
				pfks_pkg::DST_C3: c3_q <= mu_res;
				pfks_pkg::DST_RC: rc_q <= mu_res;
				pfks_pkg::DST_P:  p_q  <= mu_res;
				default: ;
			endcase
		end

		if (fin_fire) begin
			rkey_q.round_key_a <= err_q ? '0 : res_a;
			rkey_q.round_key_b <= err_q ? '0 : res_b;
			rkey_q.round_key_c <= err_q ? '0 : res_c;
			rkey_q.round_key_d <= err_q ? '0 : res_d;
			rkey_q.group_index <= gcnt_q;
			rkey_q.error_flag  <= err_q;
		end
	end

	a_gcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		gcnt_q <= pfks_pkg::GROUP_BITS'(pfks_pkg::MAX_GROUPS))
		else $error("group counter beyond last group");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mu_done |-> state_q == pfks_pkg::ST_WAIT)
		else $error("modular unit finished outside of wait");

	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && key_req.req_type == pfks_pkg::REQ_LOAD |=> gcnt_q == '0)
		else $error("load did not restart group counter");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rkey_valid && rkey.error_flag |-> rkey.round_key_a == '0 && rkey.round_key_b == '0
			&& rkey.round_key_c == '0 && rkey.round_key_d == '0)
		else $error("refused request carries key words");

endmodule
